FILE: rtl/core/bbmz_pkg.sv
// ----------------------------------------------------------------------------
// bbmz_pkg: shared types and constants for the beacon bearing median zone unit
// Holds the configuration record, the queued report, the queue status and
// the back-end state encoding.
// ----------------------------------------------------------------------------
package bbmz_pkg;

	localparam int BEARING_W = 15;
	localparam int DIST_W    = 16;
	localparam int ID_W      = 8;
	localparam int ZONE_W    = 2;
	localparam int RUN_W     = 8;
	localparam int CNT_W     = 32;
	localparam int WIN_CFG_W = 5;
	localparam int REG_IDX_W = 3;
	localparam int REG_DAT_W = 16;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_WANTED_BEACON  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MEDIAN_ENABLE  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_IN_USE  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_NEAR_BORDER    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FAR_LIMIT      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_REPORTS_NEEDED = 3'd5;

	// zone codes
	localparam logic [ZONE_W-1:0] ZONE_NONE  = 2'd0;
	localparam logic [ZONE_W-1:0] ZONE_CLOSE = 2'd1;
	localparam logic [ZONE_W-1:0] ZONE_BUMP  = 2'd2;

	localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

	typedef struct packed {
		logic [ID_W-1:0]      wanted_beacon;
		logic                 median_enable;
		logic [WIN_CFG_W-1:0] window_in_use;
		logic [DIST_W-1:0]    near_border;
		logic [DIST_W-1:0]    far_limit;
		logic [RUN_W-1:0]     reports_needed;
	} cfg_t;

	typedef struct packed {
		logic                        accepted;
		logic signed [BEARING_W-1:0] bearing;
		logic [DIST_W-1:0]           distance;
		logic [ZONE_W-1:0]           zone;
	} report_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_WALK,
		B_HOLD
	} back_state_t;

endpackage

FILE: rtl/core/bbmz_front.sv
// ----------------------------------------------------------------------------
// bbmz_front: report intake and distance zone qualifier
// Accepts reports, rejects foreign beacons, keeps the consecutive-run counts
// of both distance bands and pushes a classified report into the queue.
// ----------------------------------------------------------------------------
module bbmz_front import bbmz_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ID_W-1:0]             beacon_id,
	input  logic signed [BEARING_W-1:0] bearing_in,
	input  logic [DIST_W-1:0]           distance_in,
	input  queue_stat_t                 q_stat,
	output logic                        push,
	output report_t                     push_item
);

	logic [RUN_W-1:0] close_run_q, bump_run_q;
	logic [RUN_W-1:0] close_run_nx, bump_run_nx;
	logic             match, in_close, in_bump;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;
	assign match    = (beacon_id == cfg.wanted_beacon);
	assign in_bump  = (distance_in < cfg.near_border);
	assign in_close = (distance_in >= cfg.near_border) && (distance_in < cfg.far_limit);

	always_comb begin
		close_run_nx = '0;
		bump_run_nx  = '0;
		if (in_close) begin
			close_run_nx = (close_run_q == RUN_MAX) ? RUN_MAX : close_run_q + RUN_W'(1);
		end
		if (in_bump) begin
			bump_run_nx = (bump_run_q == RUN_MAX) ? RUN_MAX : bump_run_q + RUN_W'(1);
		end
	end

	always_comb begin
		push_item.accepted = match;
		push_item.bearing  = match ? bearing_in : '0;
		push_item.distance = match ? distance_in : '0;
		push_item.zone     = ZONE_NONE;
		if (match) begin
			priority if (in_bump && bump_run_nx >= cfg.reports_needed) begin
				push_item.zone = ZONE_BUMP;
			end else if (in_close && close_run_nx >= cfg.reports_needed) begin
				push_item.zone = ZONE_CLOSE;
			end
		end
	end

	// foreign beacons leave the run counts alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_run_q <= '0;
			bump_run_q  <= '0;
		end else if (push && match) begin
			close_run_q <= close_run_nx;
			bump_run_q  <= bump_run_nx;
		end
	end

endmodule

FILE: rtl/core/bbmz_queue.sv
// ----------------------------------------------------------------------------
// bbmz_queue: two-entry report queue
// Decouples the intake from the median back end.
// ----------------------------------------------------------------------------
module bbmz_queue import bbmz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  report_t     push_item,
	input  logic        pop,
	output report_t     pop_item,
	output queue_stat_t stat
);

	report_t    slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_item   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

FILE: rtl/core/bbmz_back.sv
// ----------------------------------------------------------------------------
// bbmz_back: bearing ring and median walk
// Writes accepted bearings into the ring and finds the upper median by
// ranking one candidate entry per cycle against the whole window.
// ----------------------------------------------------------------------------
module bbmz_back import bbmz_pkg::*; #(
	parameter int WINDOW_MAX = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  queue_stat_t                 q_stat,
	input  report_t                     q_item,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        accepted,
	output logic signed [BEARING_W-1:0] bearing_out,
	output logic [DIST_W-1:0]           distance_out,
	output logic [ZONE_W-1:0]           zone_out
);

	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WL = $clog2(WINDOW_MAX + 1);

	back_state_t state_q, state_nx;

	logic signed [BEARING_W-1:0] ring_q [WINDOW_MAX];
	logic [IW-1:0]               res_q  [WINDOW_MAX];
	logic [CNT_W-1:0]            cnt_q;
	logic [IW-1:0]               cand_q;

	logic                        accepted_q;
	logic signed [BEARING_W-1:0] bearing_q;
	logic [DIST_W-1:0]           distance_q;
	logic [ZONE_W-1:0]           zone_q;

	logic [WL-1:0]               win_len, med_rank, lt_cnt, le_cnt;
	logic [IW-1:0]               last_idx, slot;
	logic signed [BEARING_W-1:0] cand_val;
	logic                        found, last, take, wr_ring;

	// clamp the window to 1..WINDOW_MAX
	always_comb begin
		priority if (cfg.window_in_use == '0) begin
			win_len = WL'(1);
		end else if (int'(cfg.window_in_use) > WINDOW_MAX) begin
			win_len = WL'(WINDOW_MAX);
		end else begin
			win_len = WL'(cfg.window_in_use);
		end
	end

	assign med_rank = win_len >> 1;
	assign last_idx = IW'(win_len - WL'(1));
	assign slot     = res_q[last_idx];
	assign cand_val = ring_q[cand_q];
	assign last     = (cand_q == last_idx);

	// rank the candidate against every entry of the window
	always_comb begin
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < WINDOW_MAX; j++) begin
			if (WL'(j) < win_len) begin
				if (ring_q[j] < cand_val) begin
					lt_cnt = lt_cnt + WL'(1);
				end
				if (ring_q[j] <= cand_val) begin
					le_cnt = le_cnt + WL'(1);
				end
			end
		end
	end

	assign found = (lt_cnt <= med_rank) && (med_rank < le_cnt);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_stat.empty) begin
					state_nx = (q_item.accepted && cfg.median_enable) ? B_WALK : B_HOLD;
				end
			end
			B_WALK: begin
				if (found || last) begin
					state_nx = B_HOLD;
				end
			end
			B_HOLD: begin
				if (out_ready) begin
					state_nx = B_IDLE;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == B_IDLE) && !q_stat.empty;
		take      = (state_q == B_WALK) && (found || last);
		out_valid = (state_q == B_HOLD);
		wr_ring   = pop && q_item.accepted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cand_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (pop) begin
				cand_q <= '0;
			end else if (state_q == B_WALK) begin
				cand_q <= cand_q + IW'(1);
			end
		end
	end

	// ring, accepted-report count and its residue modulo every window length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int k = 0; k < WINDOW_MAX; k++) begin
				ring_q[k] <= '0;
				res_q[k]  <= '0;
			end
		end else if (wr_ring) begin
			ring_q[slot] <= q_item.bearing;
			cnt_q        <= cnt_q + CNT_W'(1);
			for (int k = 0; k < WINDOW_MAX; k++) begin
				// the count wraps to zero, so every residue restarts
				if (cnt_q == '1 || res_q[k] == IW'(k)) begin
					res_q[k] <= '0;
				end else begin
					res_q[k] <= res_q[k] + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			accepted_q <= q_item.accepted;
			bearing_q  <= q_item.bearing;
			distance_q <= q_item.distance;
			zone_q     <= q_item.zone;
		end else if (take) begin
			bearing_q <= cand_val;
		end
	end

	assign accepted     = accepted_q;
	assign bearing_out  = bearing_q;
	assign distance_out = distance_q;
	assign zone_out     = zone_q;

endmodule

FILE: rtl/core/beacon_bearing_median_zone_unit.sv
// ----------------------------------------------------------------------------
// beacon_bearing_median_zone_unit: beacon bearing median filter and zone flag
// Top level: configuration registers, intake, report queue and median back end.
// ----------------------------------------------------------------------------
// Every report gives one result. A report from another beacon comes back with
// accepted low and all fields zero and changes nothing. Intake takes a report
// in the cycle it is offered as long as the two-entry queue has room, also
// while a result waits on out_ready. The back end handles one report at a
// time: it loads the report from the queue and writes the bearing ring, then,
// with the median on, ranks one candidate entry per cycle (1 to W entries, W
// the clamped window length), and the result is shown from the next cycle on.
// A rejected report, or any report with the median off, skips the walk.
// The ring resets to zero and those zeros count in the median until filled.
// ----------------------------------------------------------------------------
module beacon_bearing_median_zone_unit import bbmz_pkg::*; #(
	parameter int WINDOW_MAX = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [REG_IDX_W-1:0]        wr_index,
	input  logic [REG_DAT_W-1:0]        wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ID_W-1:0]             beacon_id,
	input  logic signed [BEARING_W-1:0] bearing_in,
	input  logic [DIST_W-1:0]           distance_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        accepted,
	output logic signed [BEARING_W-1:0] bearing_out,
	output logic [DIST_W-1:0]           distance_out,
	output logic [ZONE_W-1:0]           zone_out
);

	cfg_t        cfg_q;
	queue_stat_t q_stat;
	report_t     push_item, pop_item;
	logic        push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_beacon  <= 8'd0;
			cfg_q.median_enable  <= 1'b1;
			cfg_q.window_in_use  <= 5'd8;
			cfg_q.near_border    <= 16'd512;
			cfg_q.far_limit      <= 16'hFFFF;
			cfg_q.reports_needed <= 8'd3;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WANTED_BEACON:  cfg_q.wanted_beacon  <= wr_data[ID_W-1:0];
				REG_MEDIAN_ENABLE:  cfg_q.median_enable  <= wr_data[0];
				REG_WINDOW_IN_USE:  cfg_q.window_in_use  <= wr_data[WIN_CFG_W-1:0];
				REG_NEAR_BORDER:    cfg_q.near_border    <= wr_data;
				REG_FAR_LIMIT:      cfg_q.far_limit      <= wr_data;
				REG_REPORTS_NEEDED: cfg_q.reports_needed <= wr_data[RUN_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	bbmz_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.beacon_id   (beacon_id),
		.bearing_in  (bearing_in),
		.distance_in (distance_in),
		.q_stat      (q_stat),
		.push        (push),
		.push_item   (push_item)
	);

	bbmz_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	bbmz_back #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_stat       (q_stat),
		.q_item       (pop_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.bearing_out  (bearing_out),
		.distance_out (distance_out),
		.zone_out     (zone_out)
	);

	// rejected reports carry nothing
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> bearing_out == '0 && distance_out == '0 && zone_out == ZONE_NONE)
		else $error("rejected report carries data");

	// bump zone only below the border
	a_bump_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zone_out == ZONE_BUMP |-> accepted && distance_out < cfg_q.near_border)
		else $error("bump zone outside bump band");

	// close-in zone only inside its band
	a_close_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zone_out == ZONE_CLOSE |->
			accepted && distance_out >= cfg_q.near_border && distance_out < cfg_q.far_limit)
		else $error("close-in zone outside close-in band");

	// no back-end load while the queue is empty or a result is pending
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty && !out_valid)
		else $error("load from empty queue or over a pending result");

endmodule
